FILE: sv/dq_pkg.sv
// dq_pkg: shared types and codes for the double-ended queue.
// Request codes, status codes and the per-cell control struct.
// No dependencies.
`default_nettype none

package dq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_REAR  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_QUERY      = 3'd4
  } req_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_code_t;

  typedef struct packed {
    logic shift_up;    // push front: every item moves one cell toward the rear
    logic shift_down;  // pop front: every item moves one cell toward the front
    logic load_tail;   // push rear: the cell just past the rear takes the item
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/dq_if.sv
// dq_req_if / dq_rsp_if: valid/ready channels of the double-ended queue.
// Depends on dq_pkg for field widths.
`default_nettype none

interface dq_req_if;
  import dq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface dq_rsp_if #(
  parameter int CNT_W = 5
);
  import dq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] rear_value;
  logic [CNT_W-1:0]          item_count;

  modport source (output valid, status, front_value, rear_value, item_count, input ready);
  modport sink   (input valid, status, front_value, rear_value, item_count, output ready);
endinterface

`default_nettype wire

FILE: sv/dq_cell.sv
// dq_cell: one slot of the shifting item chain.
// Takes its neighbor's item on front pushes and pops, or the new item on a rear push.
// Depends on dq_pkg.
`default_nettype none

module dq_cell
  import dq_pkg::*;
#(
  parameter int CNT_W = 5
) (
  input  wire logic                      clk,
  input  wire cell_ctrl_t                ctrl,
  input  wire logic [CNT_W-1:0]          index,
  input  wire logic [CNT_W-1:0]          count,
  input  wire logic [CNT_W-1:0]          count_next,
  input  wire logic signed [VALUE_W-1:0] left_val,
  input  wire logic signed [VALUE_W-1:0] right_val,
  input  wire logic signed [VALUE_W-1:0] push_value,
  output logic signed [VALUE_W-1:0]      value,
  output logic signed [VALUE_W-1:0]      value_next,
  output logic signed [VALUE_W-1:0]      tail_val
);

  always_comb begin
    value_next = value;
    if (ctrl.shift_up) begin
      value_next = left_val;
    end else if (ctrl.shift_down) begin
      value_next = right_val;
    end else if (ctrl.load_tail && (index == count)) begin
      value_next = push_value;
    end
  end

  // masked item, nonzero only in the cell that holds the rear after this transaction
  assign tail_val = ((index + CNT_W'(1)) == count_next) ? value_next : '0;

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

FILE: sv/dq_ctrl.sv
// dq_ctrl: request decode, item count and status for the double-ended queue.
// Drives the shared control of the cell chain. Depends on dq_pkg.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [REQ_W-1:0]  req_type,
  output cell_ctrl_t             ctrl,
  output logic [CNT_W-1:0]       count,
  output logic [CNT_W-1:0]       count_next,
  output status_code_t           status
);

  logic full;
  logic empty;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ctrl       = '0;
    count_next = count;
    status     = ST_OK;
    unique case (req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status = ST_OVER;
        end else begin
          ctrl.shift_up = fire;
          count_next    = count + CNT_W'(1);
        end
      end
      REQ_PUSH_REAR: begin
        if (full) begin
          status = ST_OVER;
        end else begin
          ctrl.load_tail = fire;
          count_next     = count + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status = ST_UNDER;
        end else begin
          ctrl.shift_down = fire;
          count_next      = count - CNT_W'(1);
        end
      end
      REQ_POP_REAR: begin
        if (empty) begin
          status = ST_UNDER;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        if (empty) begin
          status = ST_UNDER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/double_ended_queue.sv
// double_ended_queue: bounded deque of signed 32-bit items on a shifting cell chain.
// Top level. Depends on dq_pkg, dq_if, dq_ctrl and dq_cell.
//
// Usage:
//   req channel (sink): req_type selects push front, push rear, pop front,
//   pop rear or query (codes five to seven act as query); push_value is the
//   item for pushes. rsp channel (source): one transaction per request with
//   status (ok, underflow, overflow), front and rear items after the request
//   (zero when empty) and the item count.
//   Items sit in a row of DEPTH cells with the front always in cell 0; front
//   operations shift the whole row by one cell, a rear push writes only the
//   cell at the count and a rear pop writes none. The rear is picked by a
//   one-hot select over cells. Latency: the response is registered and valid
//   the cycle after the request is accepted. Throughput: one request per cycle
//   while each response is taken. A stalled response holds the response register;
//   a new request is taken in the same cycle the held response is taken.
//   Reset: synchronous, active high; empties the queue and drops any pending
//   response. Cell contents are not cleared.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dq_req_if.sink     req,
  dq_rsp_if.source   rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                      fire;
  cell_ctrl_t                ctrl;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  status_code_t              status;
  logic signed [VALUE_W-1:0] cell_val     [DEPTH];
  logic signed [VALUE_W-1:0] cell_val_next[DEPTH];
  logic signed [VALUE_W-1:0] cell_tail    [DEPTH];
  logic signed [VALUE_W-1:0] rear_next;
  logic signed [VALUE_W-1:0] front_next;

  logic                      out_valid;
  logic [STAT_W-1:0]         out_status;
  logic signed [VALUE_W-1:0] out_front;
  logic signed [VALUE_W-1:0] out_rear;
  logic [CNT_W-1:0]          out_count;

  assign req.ready = !out_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  dq_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req_type   (req.req_type),
    .ctrl       (ctrl),
    .count      (count),
    .count_next (count_next),
    .status     (status)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val;
    logic signed [VALUE_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = req.push_value;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    dq_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .index      (CNT_W'(i)),
      .count      (count),
      .count_next (count_next),
      .left_val   (left_val),
      .right_val  (right_val),
      .push_value (req.push_value),
      .value      (cell_val[i]),
      .value_next (cell_val_next[i]),
      .tail_val   (cell_tail[i])
    );
  end

  always_comb begin
    rear_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_next = rear_next | cell_tail[i];
    end
  end

  assign front_next = (count_next == '0) ? '0 : cell_val_next[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= status;
      out_front  <= front_next;
      out_rear   <= rear_next;
      out_count  <= count_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.front_value = out_front;
  assign rsp.rear_value  = out_rear;
  assign rsp.item_count  = out_count;

endmodule

`default_nettype wire
